// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned POS_W  = 4;

  typedef struct packed {
    logic latch;
    logic start_rd;
    logic step;
    logic shift_wr;
    logic place;
    logic place_zero;
    logic pop_commit;
    logic set_empty;
    logic set_full;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op_pop;
    logic occ_zero;
    logic occ_full;
    logic greater;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/spq_in_if.sv -----
interface spq_in_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   entry_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, output op, output entry_id, output priority_req, input ready);
  modport sink (input valid, input op, input entry_id, input priority_req, output ready);
endinterface

// ----- rtl/core/spq_out_if.sv -----
interface spq_out_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [ID_W-1:0]   head_id;
  logic [PRIO_W-1:0] head_priority;
  logic              was_empty;
  logic              was_full;

  modport source (
    output valid, output position, output head_id, output head_priority,
    output was_empty, output was_full, input ready
  );
  modport sink (
    input valid, input position, input head_id, input head_priority,
    input was_empty, input was_full, output ready
  );
endinterface

// ----- rtl/core/sorted_priority_queue_core.sv -----
// An item is accepted in the idle cycle and is then dispatched: a pop reads the head slot and
// commits, and an insert walks back from the tail past every stored entry of greater priority,
// shifting each up one slot, before it places the item; a pop of an empty queue or an insert
// into an empty or full queue goes straight to its result. The next item can be accepted in the
// cycle after the result is loaded; a result that waits for the sink holds off the input.
// Reset clears the occupancy, head pointer and output valid; the slot RAM is not cleared.
module sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  cmd_t    cmd;
  status_t status;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (in_i.op),
    .entry_id_i      (in_i.entry_id),
    .priority_req_i  (in_i.priority_req),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .position_o      (out_o.position),
    .head_id_o       (out_o.head_id),
    .head_priority_o (out_o.head_priority),
    .was_empty_o     (out_o.was_empty),
    .was_full_o      (out_o.was_full)
  );

endmodule

// ----- rtl/core/spq_ram.sv -----
module spq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/spq_ctrl.sv -----
module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spq_pkg::status_t status_i,
  output spq_pkg::cmd_t    cmd_o
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_WALK     = 3'd2;
  localparam logic [2:0] S_PLACE0   = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.op_pop) begin
          if (status_i.occ_zero) begin
            cmd_o.set_empty = 1'b1;
            state_d         = S_DONE;
          end else begin
            cmd_o.start_rd = 1'b1;
            state_d        = S_POP;
          end
        end else if (status_i.occ_full) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_DONE;
        end else if (status_i.occ_zero) begin
          cmd_o.place      = 1'b1;
          cmd_o.place_zero = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.start_rd = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        if (status_i.greater) begin
          cmd_o.shift_wr = 1'b1;
          if (status_i.idx_zero) begin
            state_d = S_PLACE0;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_PLACE0: begin
        cmd_o.place      = 1'b1;
        cmd_o.place_zero = 1'b1;
        state_d          = S_DONE;
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/spq_dp.sv -----
module spq_dp #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::cmd_t                 cmd_i,
  output spq_pkg::status_t              status_o,
  input  logic                          op_i,
  input  logic [spq_pkg::ID_W-1:0]      entry_id_i,
  input  logic [spq_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [spq_pkg::POS_W-1:0]     position_o,
  output logic [spq_pkg::ID_W-1:0]      head_id_o,
  output logic [spq_pkg::PRIO_W-1:0]    head_priority_o,
  output logic                          was_empty_o,
  output logic                          was_full_o
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int unsigned MW = ID_W + PW;
  localparam logic [IW:0] DEPTH_V = (IW + 1)'(QUEUE_DEPTH);
  localparam logic [OW-1:0] FULL_V = OW'(QUEUE_DEPTH);

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[IW-1:0];
  endfunction

  logic [IW-1:0]          head_q;
  logic [OW-1:0]          occ_q;
  logic [IW-1:0]          idx_q;
  logic                   op_q;
  logic [ID_W-1:0]        id_q;
  logic [PW-1:0]          prio_q;
  logic [POS_W-1:0]       res_pos_q;
  logic [ID_W-1:0]        res_id_q;
  logic [PRIO_W-1:0]      res_prio_q;
  logic                   res_empty_q;
  logic                   res_full_q;
  logic                   out_valid_q;

  logic [MW-1:0]          rdata;
  logic [MW-1:0]          wdata;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          wr_addr;
  logic [IW-1:0]          wr_lp;
  logic [IW-1:0]          idx_p1;
  logic [IW-1:0]          idx_m1;
  logic [OW-1:0]          occ_m1;
  logic [ID_W-1:0]        rd_id;
  logic [PW-1:0]          rd_prio;
  logic [POS_W+IW-1:0]    pos_ext;
  logic [PRIO_W+PW-1:0]   prio_ext;
  logic                   we;

  assign rd_id    = rdata[MW-1:PW];
  assign rd_prio  = rdata[PW-1:0];
  assign idx_p1   = idx_q + 1'b1;
  assign idx_m1   = idx_q - 1'b1;
  assign occ_m1   = occ_q - 1'b1;
  assign rd_addr  = cmd_i.start_rd ? (op_q ? head_q : wrap_add(head_q, occ_m1[IW-1:0]))
                                   : wrap_add(head_q, idx_m1);
  assign wr_lp    = cmd_i.place_zero ? '0 : idx_p1;
  assign wr_addr  = wrap_add(head_q, wr_lp);
  assign we       = cmd_i.shift_wr | cmd_i.place;
  assign wdata    = cmd_i.place ? {id_q, prio_q} : rdata;
  assign pos_ext  = {{POS_W{1'b0}}, wr_lp};
  assign prio_ext = {{PRIO_W{1'b0}}, rd_prio};

  spq_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.place) begin
        occ_q <= occ_q + 1'b1;
      end else if (cmd_i.pop_commit) begin
        occ_q  <= occ_m1;
        head_q <= wrap_add(head_q, IW'(1));
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      id_q   <= entry_id_i;
      prio_q <= priority_req_i[PW-1:0];
    end
    if (cmd_i.start_rd) begin
      idx_q <= occ_m1[IW-1:0];
    end else if (cmd_i.step) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.set_empty || cmd_i.set_full || cmd_i.place || cmd_i.pop_commit) begin
      res_pos_q   <= cmd_i.place ? pos_ext[POS_W-1:0] : '0;
      res_id_q    <= cmd_i.pop_commit ? rd_id : '0;
      res_prio_q  <= cmd_i.pop_commit ? prio_ext[PRIO_W-1:0] : '0;
      res_empty_q <= cmd_i.set_empty;
      res_full_q  <= cmd_i.set_full;
    end
    if (cmd_i.load_out) begin
      position_o      <= res_pos_q;
      head_id_o       <= res_id_q;
      head_priority_o <= res_prio_q;
      was_empty_o     <= res_empty_q;
      was_full_o      <= res_full_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.op_pop   = op_q;
  assign status_o.occ_zero = (occ_q == '0);
  assign status_o.occ_full = (occ_q == FULL_V);
  assign status_o.greater  = (rd_prio > prio_q);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
